// File: hw/rtl/cts_pkg.sv
// Shared types, constants and the reciprocal table for the cosine series block.
package cts_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int MAX_TERM_LIMIT = 26;
  localparam int SUM_FRAC       = 30;
  localparam int RECIP_FRAC     = 25;
  localparam int X2_FRAC        = 26;

  localparam int ANGLE_W = 16;
  localparam int TL_W    = 5;
  localparam int OUT_W   = 32;
  localparam int X2_W    = 31;
  localparam int T_W     = 34;
  localparam int RECIP_W = 25;
  localparam int SUM_W   = 40;
  localparam int MA_W    = 38;
  localparam int MB_W    = 31;
  localparam int MP_W    = MA_W + MB_W;
  localparam int MC_W    = X2_FRAC;
  localparam int KW      = $clog2(MAX_TERM_LIMIT + 3);
  localparam int SHIFT   = SUM_FRAC - FRAC_BITS;

  localparam logic [T_W-1:0]   T_ONE    = T_W'(1) << SUM_FRAC;
  localparam logic [SUM_W-1:0] SUM_ONE  = SUM_W'(1) << SUM_FRAC;
  localparam logic [SUM_W-1:0] RND_HALF = SUM_W'((1 << SHIFT) >> 1);
  localparam logic [SUM_W-1:0] NEG_LIM  = SUM_W'(1) << (OUT_W - 1);
  localparam logic [SUM_W-1:0] POS_LIM  = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
  localparam logic [MC_W-1:0]  RND_X2   = MC_W'(1) << (X2_FRAC - 1);
  localparam logic [MC_W-1:0]  RND_RCP  = MC_W'(1) << (RECIP_FRAC - 1);
  localparam logic [KW-1:0]    K_FIRST  = KW'(2);
  localparam logic [KW-1:0]    K_STEP   = KW'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X2,
    ST_M1,
    ST_M2,
    ST_ACC,
    ST_FIN,
    ST_RND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            en;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
    logic [MC_W-1:0] c;
  } mul_req_t;

  // round(2^25 / ((k-1)k)), even k
  function automatic logic [RECIP_W-1:0] recip_of(input logic [KW-1:0] k);
    logic [RECIP_W-1:0] r;
    case (int'(k))
      2:       r = RECIP_W'(16777216);
      4:       r = RECIP_W'(2796203);
      6:       r = RECIP_W'(1118481);
      8:       r = RECIP_W'(599186);
      10:      r = RECIP_W'(372827);
      12:      r = RECIP_W'(254200);
      14:      r = RECIP_W'(184365);
      16:      r = RECIP_W'(139810);
      18:      r = RECIP_W'(109655);
      20:      r = RECIP_W'(88301);
      22:      r = RECIP_W'(72629);
      24:      r = RECIP_W'(60787);
      26:      r = RECIP_W'(51622);
      28:      r = RECIP_W'(44384);
      30:      r = RECIP_W'(38568);
      32:      r = RECIP_W'(33825);
      34:      r = RECIP_W'(29906);
      36:      r = RECIP_W'(26631);
      38:      r = RECIP_W'(23865);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/cts_mul.sv
// Shared multiply-add unit with registered product.
module cts_mul import cts_pkg::*; (
  input  logic            clk,
  input  mul_req_t        req,
  output logic [MP_W-1:0] prod
);

  logic [MP_W-1:0] mult;

  assign mult = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= mult + MP_W'(req.c);
    end
  end

endmodule

// File: hw/rtl/cts_seq.sv
// Series sequencer: term recurrence, accumulation, rounding and saturation.
module cts_seq import cts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [KW-1:0]             lim_in,
  output mul_req_t                  mreq,
  input  logic [MP_W-1:0]           prod,
  output logic                      done,
  output logic signed [OUT_W-1:0]   cosine_value,
  output logic                      saturated
);

  state_t state, state_next;

  logic [KW-1:0]           k, lim;
  logic [X2_W-1:0]         x2;
  logic [T_W-1:0]          t;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        mag;
  logic                    neg;

  logic [ANGLE_W-1:0]      abs_angle;
  logic [KW-1:0]           k_next;
  logic [T_W-1:0]          term;
  logic signed [SUM_W-1:0] sum_acc;
  logic                    sat_hit;
  logic [SUM_W-1:0]        mag_sel;

  assign abs_angle = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
  assign k_next    = k + K_STEP;
  assign term      = prod[RECIP_FRAC +: T_W];
  assign sum_acc   = k[1] ? sum - $signed(SUM_W'(term)) : sum + $signed(SUM_W'(term));
  assign sat_hit   = neg ? (mag > NEG_LIM) : (mag > POS_LIM);
  assign mag_sel   = sat_hit ? (neg ? NEG_LIM : POS_LIM) : mag;
  assign busy      = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    mreq       = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          mreq.en    = 1'b1;
          mreq.a     = MA_W'(abs_angle);
          mreq.b     = MB_W'(abs_angle);
          state_next = ST_X2;
        end
      end
      ST_X2: begin
        state_next = (K_FIRST < lim) ? ST_M1 : ST_FIN;
      end
      ST_M1: begin
        mreq.en    = 1'b1;
        mreq.a     = MA_W'(t);
        mreq.b     = MB_W'(x2);
        mreq.c     = RND_X2;
        state_next = ST_M2;
      end
      ST_M2: begin
        mreq.en    = 1'b1;
        mreq.a     = prod[X2_FRAC +: MA_W];
        mreq.b     = MB_W'(recip_of(k));
        mreq.c     = RND_RCP;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = (k_next < lim) ? ST_M1 : ST_FIN;
      end
      ST_FIN:  state_next = ST_RND;
      ST_RND:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          lim <= lim_in;
        end
      end
      ST_X2: begin
        x2  <= prod[X2_W-1:0];
        t   <= T_ONE;
        sum <= $signed(SUM_ONE);
        k   <= K_FIRST;
      end
      ST_ACC: begin
        t   <= term;
        sum <= sum_acc;
        k   <= k_next;
      end
      ST_FIN: begin
        neg <= sum[SUM_W-1];
        mag <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      end
      ST_RND: begin
        mag <= (mag + RND_HALF) >> SHIFT;
      end
      ST_OUT: begin
        cosine_value <= neg ? OUT_W'(-mag_sel) : OUT_W'(mag_sel);
        saturated    <= sat_hit;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/cosine_taylor_series_top.sv
// Top level of the fixed-point cosine series block: config register and units.
//
//  channel   direction  handshake                 payload
//  item in   in         start, accepted if !busy  angle (Q2.13)
//  config    in         cfg_valid / cfg_ready     cfg_data (term_limit)
//  result    out        done, one-cycle strobe    cosine_value (Q7.24), saturated
//
// With n even powers summed (2 <= k < limit, limit capped at 26) busy stays high
// through ST_X2, ST_M1, ST_M2 and ST_ACC per term, ST_FIN, ST_RND and ST_OUT; done pulses in the cycle after that.
// The single multiply-add unit is used twice per term plus once for the square.
// rst is synchronous; it restores term_limit to 8 and drops any item in flight.
// cfg_ready is always high. done cannot be held off.
module cosine_taylor_series_top import cts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TL_W-1:0]           cfg_data,
  output logic                      done,
  output logic signed [OUT_W-1:0]   cosine_value,
  output logic                      saturated
);

  logic [TL_W-1:0] term_limit;
  logic [KW-1:0]   lim_eff;
  mul_req_t        mreq;
  logic [MP_W-1:0] prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_limit <= TL_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      term_limit <= cfg_data;
    end
  end

  assign lim_eff = ((KW + 1)'(term_limit) > (KW + 1)'(MAX_TERM_LIMIT)) ?
                   KW'(MAX_TERM_LIMIT) : KW'(term_limit);

  cts_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  cts_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .angle        (angle),
    .lim_in       (lim_eff),
    .mreq         (mreq),
    .prod         (prod),
    .done         (done),
    .cosine_value (cosine_value),
    .saturated    (saturated)
  );

endmodule
